FILE: rtl/xtea_pkg.sv
// Shared types, constants and the round mixing function for the XTEA cipher.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package xtea_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned KeyWords = 4;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [WordW-1:0] Delta = 32'h9E37_79B9;

  // Request codes
  typedef enum logic {
    REQ_ENCRYPT = 1'b0,
    REQ_DECRYPT = 1'b1
  } req_type_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_WORD_0 = 3'd0,
    CFG_KEY_WORD_1 = 3'd1,
    CFG_KEY_WORD_2 = 3'd2,
    CFG_KEY_WORD_3 = 3'd3
  } cfg_reg_e;

  typedef logic [KeyWords-1:0][WordW-1:0] key_t;

  typedef struct packed {
    logic             req_type;
    logic [WordW-1:0] word_in_0;
    logic [WordW-1:0] word_in_1;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0] word_out_0;
    logic [WordW-1:0] word_out_1;
  } rsp_t;

  // Data carried from cell to cell
  typedef struct packed {
    logic             dec;    // decrypt transfer
    logic             phase;  // 0: first half-round of a cycle, 1: second
    logic [WordW-1:0] sum;
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
  } pipe_t;

  function automatic logic [WordW-1:0] mix(input logic [WordW-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/xtea_cell.sv
// One XTEA half-round with its output register; cells are chained in the top level.
// Depends on xtea_pkg.
`default_nettype none

module xtea_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  xtea_pkg::key_t  key_i,
  input  logic            valid_i,
  input  xtea_pkg::pipe_t data_i,
  output logic            valid_o,
  output xtea_pkg::pipe_t data_o
);
  import xtea_pkg::*;

  logic             sel_hi;
  logic [1:0]       kidx;
  logic [WordW-1:0] src, tgt, fval, tgt_n;
  pipe_t            data_d, data_q;
  logic             valid_q;

  // enc/phase0 and dec/phase1 update v0 with key[sum&3];
  // the other two update v1 with key[(sum>>11)&3]
  always_comb begin
    sel_hi = data_i.phase ^ data_i.dec;
    src    = sel_hi ? data_i.v0 : data_i.v1;
    tgt    = sel_hi ? data_i.v1 : data_i.v0;
    kidx   = sel_hi ? data_i.sum[12:11] : data_i.sum[1:0];
    fval   = mix(src) ^ (data_i.sum + key_i[kidx]);
    tgt_n  = data_i.dec ? (tgt - fval) : (tgt + fval);

    data_d       = data_i;
    data_d.phase = ~data_i.phase;
    if (!data_i.phase) begin
      data_d.sum = data_i.dec ? (data_i.sum - Delta) : (data_i.sum + Delta);
    end
    if (sel_hi) begin
      data_d.v1 = tgt_n;
    end else begin
      data_d.v0 = tgt_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/xtea_block_cipher.sv
// Top level of the pipelined XTEA block cipher: key registers, input stage, cell chain.
// Depends on xtea_pkg and xtea_cell.
`default_nettype none

// XTEA block cipher, fully pipelined. A block is taken on every clock edge
// with start_i high; busy_o is never raised, so a new block may follow in the
// very next cycle. Each block passes an input register and then a chain of
// 2*CYCLES half-round cells, one register each; the last cell drives res_o
// and res_valid_o. Results come out in transfer order. The result is shown
// for one cycle only: the receiver must take it then, and there is no
// back-pressure.
// The 128-bit key lives in four 32-bit registers written through the cfg
// channel (index 0..3, higher indexes are ignored; cfg_ready_o is always
// high). Key writes take effect at once on all cells, so write the key only
// while no block is in flight.
module xtea_block_cipher #(
  parameter int unsigned CYCLES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // block request
  input  logic                          start_i,
  output logic                          busy_o,
  input  xtea_pkg::req_t                req_i,
  // result
  output logic                          res_valid_o,
  output xtea_pkg::rsp_t                res_o,
  // key configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [xtea_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [xtea_pkg::WordW-1:0]    cfg_data_i
);
  import xtea_pkg::*;

  localparam int unsigned NumCells = 2 * CYCLES;
  // decryption starts from delta * CYCLES mod 2^32
  localparam logic [63:0]       DecProd = 64'(Delta) * 64'(CYCLES);
  localparam logic [WordW-1:0]  DecSum  = DecProd[WordW-1:0];

  logic  accept;
  key_t  key_q;
  logic  in_valid_q;
  pipe_t in_data_q, in_data_d;

  logic  [NumCells:0] valid_chain;
  pipe_t [NumCells:0] data_chain;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_KEY_WORD_0: key_q[0] <= cfg_data_i;
        CFG_KEY_WORD_1: key_q[1] <= cfg_data_i;
        CFG_KEY_WORD_2: key_q[2] <= cfg_data_i;
        CFG_KEY_WORD_3: key_q[3] <= cfg_data_i;
        default: ;  // beyond the key: dropped
      endcase
    end
  end

  // Input stage: load the block and its starting sum
  always_comb begin
    in_data_d.dec   = (req_i.req_type == REQ_DECRYPT);
    in_data_d.phase = 1'b0;
    in_data_d.sum   = in_data_d.dec ? DecSum : '0;
    in_data_d.v0    = req_i.word_in_0;
    in_data_d.v1    = req_i.word_in_1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    in_data_q <= in_data_d;
  end

  assign valid_chain[0] = in_valid_q;
  assign data_chain[0]  = in_data_q;

  // Chain of half-round cells
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    xtea_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .valid_i (valid_chain[g]),
      .data_i  (data_chain[g]),
      .valid_o (valid_chain[g+1]),
      .data_o  (data_chain[g+1])
    );
  end

  assign res_valid_o      = valid_chain[NumCells];
  assign res_o.word_out_0 = data_chain[NumCells].v0;
  assign res_o.word_out_1 = data_chain[NumCells].v1;

endmodule

`default_nettype wire

FILE: rtl/xtea_chk.sv
// Port-level checker for xtea_block_cipher, attached by the bind at the end.
// Depends on xtea_pkg.
`default_nettype none

module xtea_chk #(
  parameter int unsigned CYCLES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_o,
  input  xtea_pkg::req_t                req_i,
  input  logic                          res_valid_o,
  input  xtea_pkg::rsp_t                res_o,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [xtea_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [xtea_pkg::WordW-1:0]    cfg_data_i
);
  import xtea_pkg::*;

  localparam int unsigned Lat = 2 * CYCLES + 1;

  logic [Lat-1:0] acc_q;
  logic           accept;
  logic           unused_cfg;

  assign accept     = start_i & ~busy_o;
  assign unused_cfg = cfg_valid_i ^ (^cfg_index_i) ^ (^cfg_data_i);

  // transfer history, cleared by reset like the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= {acc_q[Lat-2:0], accept};
    end
  end

  // the block never stalls either channel
  a_never_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && cfg_ready_o))
    else $error("busy or cfg stall seen");

  // one result per transfer, fixed latency, nothing invented
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o == acc_q[Lat-1]))
    else $error("result strobe does not match transfer latency");

  // equal back-to-back blocks give equal back-to-back results
  a_same_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q[Lat-1] && $past(acc_q[Lat-1]) &&
     $past(req_i, Lat) == $past(req_i, Lat + 1)) |-> $stable(res_o))
    else $error("identical blocks gave different results");

  // no result right after reset release
  a_quiet_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !res_valid_o)
    else $error("result strobe right after reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni) unused_cfg == unused_cfg)
    else $error("cfg inputs unknown");

endmodule

bind xtea_block_cipher xtea_chk #(.CYCLES(CYCLES)) u_xtea_chk (.*);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the pipelined XTEA block cipher (xtea_block_cipher).
// Depends on rtl/xtea_pkg.sv and the cipher RTL; holds its own cipher predictor.
`timescale 1ns / 100ps

module testbench;
  import xtea_pkg::*;

  localparam int unsigned Rounds      = 32;
  // input register plus one register per half-round
  localparam int unsigned Latency     = 2 * Rounds + 1;
  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned PhaseBlocks = 170;
  localparam int unsigned CycleLimit  = 200_000;

  // cfg indexes that fall outside the key and must be ignored
  localparam logic [CfgIdxW-1:0] CfgIdxPastKey = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgIdxTop     = 3'd7;

  // sender idle rate, in percent, for each random phase group
  localparam int unsigned IdlePct[3] = '{15, 57, 0};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic                busy_o;
  req_t                req_i       = '0;
  logic                res_valid_o;
  rsp_t                res_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [WordW-1:0]    cfg_data_i  = '0;

  // ---------------------------------------------------------------------------
  // Scoreboard: key mirror, cipher predictor and the queue of expected blocks.
  // ---------------------------------------------------------------------------
  class cipher_scoreboard;
    logic [WordW-1:0] key_word[KeyWords];
    rsp_t             expected_q[$];
    int unsigned      errors;

    function new();
      foreach (key_word[i]) key_word[i] = '0;
      errors = 0;
    endfunction

    function void set_key(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] data);
      if (idx < CfgIdxPastKey) key_word[idx[1:0]] = data;
    endfunction

    function logic [WordW-1:0] feistel(logic [WordW-1:0] x);
      return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    function rsp_t predict(req_t blk);
      logic [WordW-1:0] v0, v1, sum;
      rsp_t             r;
      v0 = blk.word_in_0;
      v1 = blk.word_in_1;
      if (blk.req_type == REQ_ENCRYPT) begin
        sum = '0;
        repeat (Rounds) begin
          v0  = v0 + (feistel(v1) ^ (sum + key_word[sum[1:0]]));
          sum = sum + Delta;
          v1  = v1 + (feistel(v0) ^ (sum + key_word[sum[12:11]]));
        end
      end else begin
        sum = Delta * Rounds;  // wraps at 32 bits
        repeat (Rounds) begin
          v1  = v1 - (feistel(v0) ^ (sum + key_word[sum[12:11]]));
          sum = sum - Delta;
          v0  = v0 - (feistel(v1) ^ (sum + key_word[sum[1:0]]));
        end
      end
      r.word_out_0 = v0;
      r.word_out_1 = v1;
      return r;
    endfunction

    // called once per accepted block; returns the predicted result
    function rsp_t note_block(req_t blk);
      rsp_t r;
      r = predict(blk);
      expected_q.push_back(r);
      return r;
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: %h %h",
                 $time, got.word_out_0, got.word_out_1);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.word_out_0 !== want.word_out_0) begin
        $display("%0t: word_out_0 expected %h actual %h",
                 $time, want.word_out_0, got.word_out_0);
        errors++;
      end
      if (got.word_out_1 !== want.word_out_1) begin
        $display("%0t: word_out_1 expected %h actual %h",
                 $time, want.word_out_1, got.word_out_1);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  cipher_scoreboard sb = new();

  // last predicted ciphertext, fed back now and then as a decrypt request
  rsp_t        last_cipher;
  bit          have_cipher = 1'b0;
  int unsigned cycle_count = 0;

  xtea_block_cipher #(
    .CYCLES (Rounds)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Results: sampled right after the edge, so the values seen are the ones
  // that were on the ports during the cycle the edge closes.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_result(res_o);
  end

  // Watchdog: covers a hung pipeline or a lost valid.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout, %0d blocks still expected", $time, sb.pending());
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic logic [WordW-1:0] corner_word();
    case ($urandom_range(3, 0))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic req_t make_block(req_type_e op, logic [WordW-1:0] w0,
                                      logic [WordW-1:0] w1);
    req_t b;
    b.req_type  = op;
    b.word_in_0 = w0;
    b.word_in_1 = w1;
    return b;
  endfunction

  // Mostly random blocks; some decrypt a recent ciphertext (round trip),
  // some use corner words.
  function automatic req_t random_block();
    int unsigned pick;
    req_t        b;
    pick = $urandom_range(99, 0);
    b = make_block($urandom_range(1, 0) ? REQ_DECRYPT : REQ_ENCRYPT,
                   $urandom(), $urandom());
    if (pick < 20 && have_cipher) begin
      b = make_block(REQ_DECRYPT, last_cipher.word_out_0, last_cipher.word_out_1);
    end else if (pick < 35) begin
      b.word_in_0 = corner_word();
      b.word_in_1 = corner_word();
    end
    return b;
  endfunction

  // One block transfer. While idling, junk goes onto req_i with start low.
  // start_i stays high on return so back-to-back blocks need no toggle.
  task automatic send_block(input req_t blk, input int unsigned idle_pct);
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      req_i   <= req_t'({$urandom(), $urandom(), $urandom()});
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= blk;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    last_cipher = sb.note_block(blk);
    have_cipher = (blk.req_type == REQ_ENCRYPT);
  endtask

  // cfg transfer; cfg_valid_i is left high, the caller drops it
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_key(idx, data);
  endtask

  // Full key load, then one write past the key that must leave it untouched.
  task automatic load_key(input key_t k);
    cfg_write(CFG_KEY_WORD_0, k[0]);
    cfg_write(CFG_KEY_WORD_1, k[1]);
    cfg_write(CFG_KEY_WORD_2, k[2]);
    cfg_write(CFG_KEY_WORD_3, k[3]);
    cfg_write(CfgIdxW'($urandom_range(CfgIdxTop, CfgIdxPastKey)), $urandom());
    cfg_valid_i <= 1'b0;
  endtask

  // Key writes hit every cell at once, so the pipe must be empty first.
  task automatic wait_drained();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Directed set per key: both operations on all-zero, all-one and
  // sign-bit / lsb blocks.
  task automatic send_corner_set();
    send_block(make_block(REQ_ENCRYPT, '0, '0), 0);
    send_block(make_block(REQ_DECRYPT, '0, '0), 0);
    send_block(make_block(REQ_ENCRYPT, '1, '1), 0);
    send_block(make_block(REQ_DECRYPT, '1, '1), 0);
    send_block(make_block(REQ_ENCRYPT, 32'h8000_0000, 32'h0000_0001), 0);
    send_block(make_block(REQ_DECRYPT, 32'h0000_0001, 32'h8000_0000), 0);
  endtask

  initial begin
    key_t k;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // key never written: must behave as all zero
    send_corner_set();
    wait_drained();

    load_key('1);
    send_corner_set();
    wait_drained();

    load_key({32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h8000_0000});
    send_corner_set();
    wait_drained();

    // Random part: 15 % sender idle, then 57 %, then none; two keys each.
    for (int p = 0; p < 3; p++) begin
      for (int s = 0; s < 2; s++) begin
        foreach (k[w]) k[w] = ($urandom_range(3, 0) == 0) ? corner_word() : $urandom();
        load_key(k);
        for (int n = 0; n < PhaseBlocks; n++) send_block(random_block(), IdlePct[p]);
        wait_drained();
      end
    end

    // end with the zero key written explicitly
    load_key('0);
    for (int n = 0; n < 20; n++) send_block(random_block(), 0);
    wait_drained();

    // anything arriving after this point is a spurious result
    repeat (Latency + ResetCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: xtea_block_cipher.f
rtl/xtea_pkg.sv
rtl/xtea_cell.sv
rtl/xtea_block_cipher.sv
rtl/xtea_chk.sv
sim/testbench.sv
